// ----- sv/ordarr_pkg.sv -----
// ----------------------------------------------------------------------------
// ordarr_pkg
// Shared types and constants for the ordered array store: list depth, index
// and count widths, op and status codes, and the per-cell command word.
// ----------------------------------------------------------------------------
package ordarr_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = 8;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 5;
  localparam int OUTC_W  = 5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CMP_W-1:0]         cmp_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [OUTC_W-1:0]        outc_t;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_REVERSE = 3'd3,
    OP_SORT    = 3'd4,
    OP_DUMP    = 3'd5
  } op_code_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_APPEND,
    CM_INSERT,
    CM_DELETE,
    CM_TAG,
    CM_SORT,
    CM_REV,
    CM_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
    cnt_t     sel;
    cnt_t     used;
    word_t    val;
  } cell_cmd_t;

endpackage

// ----- sv/ordarr_cell.sv -----
// ----------------------------------------------------------------------------
// ordarr_cell
// One list slot: holds a word and an order tag, and trades them with its
// neighbors for shifts, rotation and odd-even transposition passes.
// ----------------------------------------------------------------------------
module ordarr_cell (
  input  logic                  clk,
  input  ordarr_pkg::cell_cmd_t cmd,
  input  ordarr_pkg::idx_t      idx,
  input  ordarr_pkg::word_t     left_data,
  input  ordarr_pkg::idx_t      left_tag,
  input  ordarr_pkg::word_t     right_data,
  input  ordarr_pkg::idx_t      right_tag,
  output ordarr_pkg::word_t     data,
  output ordarr_pkg::idx_t      tag
);
  import ordarr_pkg::*;

  word_t data_r, data_nxt;
  idx_t  tag_r, tag_nxt;
  cnt_t  pos;
  logic  low_side, pair_ok, val_swap, tag_swap;
  word_t pd, lo_d, hi_d;
  idx_t  pt, lo_t, hi_t;

  always_comb begin
    pos      = cnt_t'(idx);
    low_side = (idx[0] == cmd.phase);
    pd       = low_side ? right_data : left_data;
    pt       = low_side ? right_tag : left_tag;
    lo_d     = low_side ? data_r : pd;
    hi_d     = low_side ? pd : data_r;
    lo_t     = low_side ? tag_r : pt;
    hi_t     = low_side ? pt : tag_r;
    if (low_side) begin
      pair_ok = ((pos + cnt_t'(1)) < cmd.used);
    end else begin
      pair_ok = (pos != '0) && (pos < cmd.used);
    end
    val_swap = pair_ok && (lo_d > hi_d);
    tag_swap = pair_ok && (lo_t < hi_t);
    data_nxt = data_r;
    tag_nxt  = tag_r;
    case (cmd.op)
      CM_APPEND: begin
        if (pos == cmd.sel) data_nxt = cmd.val;
      end
      CM_INSERT: begin
        if (pos == cmd.sel) begin
          data_nxt = cmd.val;
        end else if (pos > cmd.sel) begin
          data_nxt = left_data;
        end
      end
      CM_DELETE: begin
        if (pos >= cmd.sel) data_nxt = right_data;
      end
      CM_TAG: begin
        tag_nxt = idx;
      end
      CM_SORT: begin
        if (val_swap) begin
          data_nxt = pd;
          tag_nxt  = pt;
        end
      end
      CM_REV: begin
        if (tag_swap) begin
          data_nxt = pd;
          tag_nxt  = pt;
        end
      end
      CM_ROTATE: begin
        if (pos < cmd.used) begin
          if ((pos + cnt_t'(1)) == cmd.used) begin
            data_nxt = cmd.val;
          end else begin
            data_nxt = right_data;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tag_r  <= tag_nxt;
  end

  assign data = data_r;
  assign tag  = tag_r;

endmodule

// ----- sv/ordered_array_store_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_array_store_unit
// List of signed words kept in a chain of slot cells; capacity set by cfg, at most DEPTH.
// ----------------------------------------------------------------------------
// Append, insert, delete and error cases: result beat registered at the
//   accept edge; next item taken once the result beat can be loaded.
// Reverse and sort: 16 odd-even passes along the chain, then the result beat.
// Dump: count beats, one per cycle while the result side is free, by rotating the chain.
// Synchronous reset: count to zero, capacity to 16, control idle; the stored
//   words are not cleared.
module ordered_array_store_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_op,
  input  logic [4:0]               in_position,
  input  logic signed [31:0]       in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [31:0]       out_data,
  output logic [4:0]               out_count,
  output logic                     out_last,
  input  logic                     cfg_we,
  input  logic [4:0]               cfg_data
);
  import ordarr_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PASS, ST_DUMP, ST_FIN} state_t;

  state_t    state_r, state_nxt;
  cnt_t      used_r, used_nxt;
  cnt_t      rem_r, rem_nxt;
  idx_t      pass_r, pass_nxt;
  logic      rev_r, rev_nxt;
  logic [4:0] cap_r;

  logic      out_valid_r;
  status_t   out_status_r;
  word_t     out_data_r;
  outc_t     out_count_r;
  logic      out_last_r;

  logic      out_free, accept, ld_out, ld_last;
  status_t   ld_status;
  word_t     ld_data;
  cell_cmd_t cmd;
  cmp_t      lim, usedx, posx, p0x;
  idx_t      p0;
  logic      full;

  word_t cell_data [DEPTH];
  idx_t  cell_tag  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t ld, rd;
    idx_t  lt, rt;
    if (i == 0) begin : g_first
      assign ld = '0;
      assign lt = '0;
    end else begin : g_mid_l
      assign ld = cell_data[i-1];
      assign lt = cell_tag[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rd = '0;
      assign rt = '0;
    end else begin : g_mid_r
      assign rd = cell_data[i+1];
      assign rt = cell_tag[i+1];
    end
    ordarr_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(i)),
      .left_data  (ld),
      .left_tag   (lt),
      .right_data (rd),
      .right_tag  (rt),
      .data       (cell_data[i]),
      .tag        (cell_tag[i])
    );
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lim   = (cmp_t'(cap_r) > cmp_t'(DEPTH)) ? cmp_t'(DEPTH) : cmp_t'(cap_r);
    usedx = cmp_t'(used_r);
    posx  = cmp_t'(in_position);
    p0x   = posx - cmp_t'(1);
    p0    = p0x[IDX_W-1:0];
    full  = (usedx >= lim);

    cmd.op    = CM_HOLD;
    cmd.phase = pass_r[0];
    cmd.sel   = used_r;
    cmd.used  = used_r;
    cmd.val   = cell_data[0];

    state_nxt = state_r;
    used_nxt  = used_r;
    rem_nxt   = rem_r;
    pass_nxt  = pass_r;
    rev_nxt   = rev_r;
    ld_out    = 1'b0;
    ld_status = STAT_OK;
    ld_data   = '0;
    ld_last   = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ld_out = 1'b1;
          case (op_code_t'(in_op))
            OP_APPEND: begin
              if (full) begin
                ld_status = STAT_FULL;
              end else begin
                cmd.op   = CM_APPEND;
                cmd.val  = in_value;
                used_nxt = used_r + cnt_t'(1);
              end
            end
            OP_INSERT: begin
              if (full) begin
                ld_status = STAT_FULL;
              end else if (posx == '0 || posx > usedx + cmp_t'(1)) begin
                ld_status = STAT_BADPOS;
              end else begin
                cmd.op   = CM_INSERT;
                cmd.sel  = cnt_t'(p0);
                cmd.val  = in_value;
                used_nxt = used_r + cnt_t'(1);
              end
            end
            OP_DELETE: begin
              if (used_r == '0) begin
                ld_status = STAT_EMPTY;
              end else if (posx == '0 || posx > usedx) begin
                ld_status = STAT_BADPOS;
              end else begin
                cmd.op   = CM_DELETE;
                cmd.sel  = cnt_t'(p0);
                ld_data  = cell_data[p0];
                used_nxt = used_r - cnt_t'(1);
              end
            end
            OP_REVERSE: begin
              ld_out    = 1'b0;
              cmd.op    = CM_TAG;
              rev_nxt   = 1'b1;
              pass_nxt  = '0;
              state_nxt = ST_PASS;
            end
            OP_SORT: begin
              ld_out    = 1'b0;
              rev_nxt   = 1'b0;
              pass_nxt  = '0;
              state_nxt = ST_PASS;
            end
            OP_DUMP: begin
              if (used_r == '0) begin
                ld_status = STAT_EMPTY;
              end else begin
                ld_out    = 1'b0;
                rem_nxt   = used_r;
                state_nxt = ST_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PASS: begin
        cmd.op   = rev_r ? CM_REV : CM_SORT;
        pass_nxt = pass_r + idx_t'(1);
        if (pass_r == idx_t'(DEPTH - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          ld_out    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ld_out  = 1'b1;
          ld_data = cell_data[0];
          ld_last = (rem_r == cnt_t'(1));
          cmd.op  = CM_ROTATE;
          rem_nxt = rem_r - cnt_t'(1);
          if (rem_r == cnt_t'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      rem_r       <= '0;
      pass_r      <= '0;
      rev_r       <= 1'b0;
      cap_r       <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      rem_r   <= rem_nxt;
      pass_r  <= pass_nxt;
      rev_r   <= rev_nxt;
      if (cfg_we) cap_r <= cfg_data;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (ld_out) begin
      out_status_r <= ld_status;
      out_data_r   <= ld_data;
      out_count_r  <= outc_t'(used_nxt);
      out_last_r   <= ld_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

endmodule

// ----- bench/tb_ordered_array_store_unit.sv -----
// ----------------------------------------------------------------------------
// tb_ordered_array_store_unit
// Self-checking bench for the ordered array store. A directed table covers
// empty, bad-position, extreme-value and spare-op cases. Random phases then
// run at several capacities (zero, one, saturating and above-depth included).
// Both channels idle at random, and the result side holds off for long stretches.
// Every result beat is checked field by field against a typed row or the list model.
// ----------------------------------------------------------------------------
module tb_ordered_array_store_unit;
  import ordarr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIRECTED      = 25;
  localparam int N_PHASES        = 11;
  localparam int ITEMS_PER_PHASE = 28;
  localparam int HOLD_CYCLES     = 250;
  localparam int SETTLE_CYCLES   = DEPTH + 8;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int MAX_REPORTS     = 40;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    status_t     status;
    word_t       data;
    logic [4:0]  count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  pos;
    word_t       val;
    logic        fixed;
    status_t     st;
    word_t       data;
    logic [4:0]  cnt;
  } dir_row_t;

  // fixed = 1: expected beat typed in; otherwise the list model decides
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_DUMP,    5'd0,  32'sd0,           1'b1, STAT_EMPTY,  32'sd0,           5'd0},
    '{OP_DELETE,  5'd1,  32'sd0,           1'b1, STAT_EMPTY,  32'sd0,           5'd0},
    '{OP_REVERSE, 5'd0,  32'sd0,           1'b1, STAT_OK,     32'sd0,           5'd0},
    '{OP_SORT,    5'd0,  32'sd0,           1'b1, STAT_OK,     32'sd0,           5'd0},
    '{OP_INSERT,  5'd0,  32'sd9,           1'b1, STAT_BADPOS, 32'sd0,           5'd0},
    '{OP_INSERT,  5'd2,  32'sd9,           1'b1, STAT_BADPOS, 32'sd0,           5'd0},
    '{OP_INSERT,  5'd1,  32'sh7FFF_FFFF,   1'b1, STAT_OK,     32'sd0,           5'd1},
    '{OP_APPEND,  5'd0,  32'sh8000_0000,   1'b1, STAT_OK,     32'sd0,           5'd2},
    '{OP_APPEND,  5'd31, 32'sd0,           1'b1, STAT_OK,     32'sd0,           5'd3},
    '{OP_APPEND,  5'd0,  32'shFFFF_FFFF,   1'b1, STAT_OK,     32'sd0,           5'd4},
    '{OP_INSERT,  5'd5,  32'sd5,           1'b1, STAT_OK,     32'sd0,           5'd5},
    '{OP_INSERT,  5'd3,  32'sd123,         1'b1, STAT_OK,     32'sd0,           5'd6},
    '{OP_DUMP,    5'd0,  32'sd0,           1'b0, STAT_OK,     32'sd0,           5'd0},
    '{OP_DELETE,  5'd0,  32'sd0,           1'b1, STAT_BADPOS, 32'sd0,           5'd6},
    '{OP_DELETE,  5'd7,  32'sd0,           1'b1, STAT_BADPOS, 32'sd0,           5'd6},
    '{OP_DELETE,  5'd31, 32'sd0,           1'b1, STAT_BADPOS, 32'sd0,           5'd6},
    '{OP_DELETE,  5'd1,  32'sd0,           1'b1, STAT_OK,     32'sh7FFF_FFFF,   5'd5},
    '{OP_REVERSE, 5'd0,  32'sd0,           1'b0, STAT_OK,     32'sd0,           5'd0},
    '{OP_DUMP,    5'd0,  32'sd0,           1'b0, STAT_OK,     32'sd0,           5'd0},
    '{OP_SORT,    5'd0,  32'sd0,           1'b0, STAT_OK,     32'sd0,           5'd0},
    '{OP_DUMP,    5'd0,  32'sd0,           1'b0, STAT_OK,     32'sd0,           5'd0},
    '{OP_SPARE_6, 5'd31, 32'shFFFF_FFFF,   1'b1, STAT_OK,     32'sd0,           5'd5},
    '{OP_SPARE_7, 5'd1,  32'sd77,          1'b1, STAT_OK,     32'sd0,           5'd5},
    '{OP_DELETE,  5'd5,  32'sd0,           1'b0, STAT_OK,     32'sd0,           5'd0},
    '{OP_INSERT,  5'd16, 32'sd1,           1'b1, STAT_BADPOS, 32'sd0,           5'd4}
  };

  localparam logic [4:0] PHASE_CAPS [N_PHASES] = '{
    5'd1, 5'd0, 5'd16, 5'd31, 5'd2, 5'd5, 5'd17, 5'd9, 5'd16, 5'd3, 5'd16
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_op = '0;
  logic [4:0]         in_position = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_data;
  logic [4:0]         out_count;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic [4:0]         cfg_data = '0;

  // list model state
  word_t      list_words [DEPTH];
  int         list_used = 0;
  logic [4:0] cap_reg = 5'd16;

  result_t    fresh_q [$];
  result_t    expected_q [$];

  int  n_fail = 0;
  int  n_items = 0;
  int  n_beats = 0;
  int  n_err_status = 0;
  int  cycle_cnt = 0;
  int  hold_asks = 0;
  bit  steady = 1'b0;

  word_t corner_words [4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 32'shFFFF_FFFF};

  ordered_array_store_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_position (in_position),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_count   (out_count),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    if (n_fail < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    n_fail++;
  endtask

  task automatic push_fresh(input status_t st, input word_t d, input logic fin);
    fresh_q.push_back('{st, d, 5'(list_used), fin});
  endtask

  // apply one list operation to the model, leaving its result beats in fresh_q
  task automatic model_list_op(input logic [2:0] op, input logic [4:0] pos,
                               input word_t val);
    int    lim;
    int    i;
    int    j;
    word_t tmp;
    word_t gone;
    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    fresh_q.delete();
    case (op)
      OP_APPEND, OP_INSERT: begin
        if (list_used >= lim) begin
          push_fresh(STAT_FULL, '0, 1'b1);
        end else if (op == OP_INSERT && (pos < 1 || pos > list_used + 1)) begin
          push_fresh(STAT_BADPOS, '0, 1'b1);
        end else begin
          if (op == OP_APPEND) begin
            list_words[list_used] = val;
          end else begin
            for (i = list_used; i >= pos; i--) list_words[i] = list_words[i-1];
            list_words[pos-1] = val;
          end
          list_used++;
          push_fresh(STAT_OK, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (list_used == 0) begin
          push_fresh(STAT_EMPTY, '0, 1'b1);
        end else if (pos < 1 || pos > list_used) begin
          push_fresh(STAT_BADPOS, '0, 1'b1);
        end else begin
          gone = list_words[pos-1];
          for (i = pos; i < list_used; i++) list_words[i-1] = list_words[i];
          list_used--;
          push_fresh(STAT_OK, gone, 1'b1);
        end
      end
      OP_REVERSE: begin
        i = 0;
        j = list_used - 1;
        while (i < j) begin
          tmp = list_words[i];
          list_words[i] = list_words[j];
          list_words[j] = tmp;
          i++;
          j--;
        end
        push_fresh(STAT_OK, '0, 1'b1);
      end
      OP_SORT: begin
        for (i = 0; i + 1 < list_used; i++) begin
          for (j = 0; j + 1 < list_used - i; j++) begin
            if (list_words[j] > list_words[j+1]) begin
              tmp = list_words[j];
              list_words[j] = list_words[j+1];
              list_words[j+1] = tmp;
            end
          end
        end
        push_fresh(STAT_OK, '0, 1'b1);
      end
      OP_DUMP: begin
        if (list_used == 0) begin
          push_fresh(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < list_used; i++) push_fresh(STAT_OK, list_words[i], i + 1 == list_used);
        end
      end
      default: push_fresh(STAT_OK, '0, 1'b1);
    endcase
  endtask

  // offer one beat, wait for acceptance, then queue what it should produce
  task automatic offer_item(input logic [2:0] op, input logic [4:0] pos, input word_t val,
                            input logic fixed, input result_t typed);
    int k;
    if (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 34) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_list_op(op, pos, val);
    n_items++;
    if (fixed) begin
      fresh_q.delete();
      fresh_q.push_back(typed);
    end
    for (k = 0; k < fresh_q.size(); k++) begin
      if (fresh_q[k].status != STAT_OK) n_err_status++;
      expected_q.push_back(fresh_q[k]);
    end
  endtask

  task automatic pick_random_item(output logic [2:0] op, output logic [4:0] pos,
                                  output word_t val);
    int lim;
    int r;
    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    r = $urandom_range(99);
    // lean on delete when the list is at its limit
    if (list_used >= lim && lim > 0 && $urandom_range(2) == 0) r = 60;
    if (r < 4)       op = r[0] ? OP_SPARE_7 : OP_SPARE_6;
    else if (r < 30) op = OP_APPEND;
    else if (r < 52) op = OP_INSERT;
    else if (r < 76) op = OP_DELETE;
    else if (r < 84) op = OP_REVERSE;
    else if (r < 92) op = OP_SORT;
    else             op = OP_DUMP;
    if ($urandom_range(99) < 12)
      pos = 5'($urandom_range(31));
    else if (op == OP_INSERT)
      pos = 5'($urandom_range(list_used + 1, 1));
    else
      pos = 5'($urandom_range((list_used > 0) ? list_used : 1, 1));
    case ($urandom_range(9))
      0:       val = corner_words[$urandom_range(3)];
      1, 2:    val = word_t'($urandom_range(6)) - 32'sd3;
      default: val = word_t'($urandom);
    endcase
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] c);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_reg = c;
  endtask

  // result side: random stalls, calm stretch, and long hold-offs on request
  always @(posedge clk) begin : result_sink
    int hold_taken;
    int hold_left;
    if (hold_asks != hold_taken) begin
      hold_taken = hold_asks;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_beats++;
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected beat: status %0d data %0d count %0d last %0b",
                                out_status, out_data, out_count, out_last));
      end else begin
        want = expected_q.pop_front();
        if (out_status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_data !== want.data)
          note_mismatch($sformatf("data %0d, want %0d", out_data, want.data));
        if (out_count !== want.count)
          note_mismatch($sformatf("count %0d, want %0d", out_count, want.count));
        if (out_last !== want.last)
          note_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt,
             expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int         ph;
    int         k;
    logic [2:0] op;
    logic [4:0] pos;
    word_t      val;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_DIRECTED; k++) begin
      offer_item(DIRECTED[k].op, DIRECTED[k].pos, DIRECTED[k].val, DIRECTED[k].fixed,
                 '{DIRECTED[k].st, DIRECTED[k].data, DIRECTED[k].cnt, 1'b1});
    end
    drain_and_settle();

    for (ph = 0; ph < N_PHASES; ph++) begin
      steady <= (ph == 7);
      write_capacity(PHASE_CAPS[ph]);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ((ph == 2 || ph == 8) && k == 6) hold_asks <= hold_asks + 1;
        pick_random_item(op, pos, val);
        offer_item(op, pos, val, 1'b0, '0);
      end
      drain_and_settle();
    end

    if (expected_q.size() != 0)
      note_mismatch($sformatf("%0d expected beats never arrived", expected_q.size()));
    $display("covered %0d items (%0d directed), %0d result beats, %0d error statuses",
             n_items, N_DIRECTED, n_beats, n_err_status);
    $display("capacities 0,1,2,3,5,9,16,17,31 with hold-offs; %0d mismatches", n_fail);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- ordered_array_store_unit.f -----
sv/ordarr_pkg.sv
sv/ordarr_cell.sv
sv/ordered_array_store_unit.sv
bench/tb_ordered_array_store_unit.sv
